>>> design/ulcg_pkg.sv
package ulcg_pkg;

  // Generator constants
  localparam logic [30:0] LCG_MOD  = 31'h7FFF_FFFF;
  localparam logic [14:0] LCG_MULT = 15'd16807;
  localparam logic [30:0] SEED_RST = 31'd1;

  // Operation codes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Configuration register indexes and reset values
  localparam int          CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 1'b1;
  localparam logic [31:0] LOWER_RST = 32'sd0;
  localparam logic [31:0] UPPER_RST = 32'sd255;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic        draw;
    logic        err;
    logic [30:0] seed;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> design/uniform_integer_lcg_generator_core.sv
// Minimal-standard multiplicative congruential generator (multiplier 16807,
// modulus 2^31-1) with a uniform integer mapping into [lower, upper], bounds in either order. Each
// transaction on the input gives exactly one result: a draw advances the
// seed and returns it with lower + floor(seed*span/2^31); a load replaces the
// seed (zero or 2^31-1 is refused and flagged). The front accepts one
// transaction per cycle into a two-entry queue while it has room. The back
// takes a load or a flagged draw straight to DONE and steps a draw through
// MUL0, MUL1, SUM and DONE, as the single 31x17 multiplier forms the 64-bit
// product in two halves before the add that follows. It takes no new entry
// until the last result has gone into the output register. Write the bound
// registers only while the block is idle.
module uniform_integer_lcg_generator_core import ulcg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [30:0]          in_seed_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_random_value,
  output logic [30:0]          out_unit_fraction,
  output logic                 out_seed_error
);

  logic [31:0] lower_r;
  logic [31:0] upper_r;
  logic        q_push;
  logic        q_pop;
  q_entry_t    q_in;
  q_entry_t    q_head;
  q_status_t   q_status;
  logic [31:0] rand_u;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_RST;
      upper_r <= UPPER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOWER: lower_r <= cfg_wdata;
        CFG_UPPER: upper_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ulcg_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_seed_value (in_seed_value),
    .q_status      (q_status),
    .q_push        (q_push),
    .q_entry       (q_in)
  );

  ulcg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  ulcg_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .lower_bound       (lower_r),
    .upper_bound       (upper_r),
    .head              (q_head),
    .q_status          (q_status),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_random_value  (rand_u),
    .out_unit_fraction (out_unit_fraction),
    .out_seed_error    (out_seed_error)
  );

  assign out_random_value = $signed(rand_u);

endmodule

>>> design/ulcg_front.sv
module ulcg_front import ulcg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [30:0] in_seed_value,
  input  q_status_t   q_status,
  output logic        q_push,
  output q_entry_t    q_entry
);

  logic [30:0] seed_r;
  logic [30:0] seed_nxt;
  logic [45:0] prod;
  logic [31:0] fold;
  logic [30:0] adv;

  assign in_ready = !q_status.full;
  assign q_push   = in_valid && in_ready;

  // Advance the seed: constant multiply, then fold the top bits back (2^31 = 1 mod M)
  assign prod = 46'(seed_r) * 46'(LCG_MULT);
  assign fold = {1'b0, prod[30:0]} + 32'(prod[45:31]);
  assign adv  = (fold >= {1'b0, LCG_MOD}) ? 31'(fold - {1'b0, LCG_MOD}) : fold[30:0];

  // Classify the transaction and work out the next seed
  always_comb begin
    seed_nxt      = seed_r;
    q_entry.draw  = 1'b0;
    q_entry.err   = 1'b0;
    q_entry.seed  = seed_r;
    if (in_operation == OP_LOAD) begin
      if ((in_seed_value == 31'd0) || (in_seed_value == LCG_MOD)) begin
        q_entry.err = 1'b1;
      end else begin
        seed_nxt = in_seed_value;
      end
      q_entry.seed = seed_nxt;
    end else if (seed_r == 31'd0) begin
      q_entry.draw = 1'b1;
      q_entry.err  = 1'b1;
      q_entry.seed = 31'd0;
    end else begin
      seed_nxt     = adv;
      q_entry.draw = 1'b1;
      q_entry.seed = adv;
    end
  end

  // Hold the seed between transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RST;
    end else if (q_push) begin
      seed_r <= seed_nxt;
    end
  end

  a_load_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && (in_operation == OP_LOAD) && (in_seed_value != 31'd0) &&
     (in_seed_value != LCG_MOD)) |=> (seed_r == $past(in_seed_value)))
    else $error("valid seed load not taken");

endmodule

>>> design/ulcg_queue.sv
module ulcg_queue import ulcg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t status
);

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign status.full  = (count_r == QCNT_W'(QDEPTH));
  assign status.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue empty but pointers differ");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (status.full && !pop) |=> (count_r == QCNT_W'(QDEPTH)))
    else $error("queue occupancy lost while full");

endmodule

>>> design/ulcg_back.sv
module ulcg_back import ulcg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] lower_bound,
  input  logic [31:0] upper_bound,
  input  q_entry_t    head,
  input  q_status_t   q_status,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_random_value,
  output logic [30:0] out_unit_fraction,
  output logic        out_seed_error
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL0 = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]  state_r;
  logic [2:0]  state_nxt;
  logic [30:0] seed_r;
  logic        err_r;
  logic [31:0] lo_c;
  logic [31:0] hi_c;
  logic [31:0] lo_r;
  logic [32:0] span_r;
  logic [47:0] p0_r;
  logic [47:0] p1_r;
  logic [31:0] value_r;
  logic        out_valid_r;
  logic [31:0] out_random_r;
  logic [30:0] out_frac_r;
  logic        out_err_r;
  logic [16:0] mul_b;
  logic [47:0] mul_p;
  logic [63:0] total;
  logic        out_load;

  assign q_pop    = (state_r == ST_IDLE) && !q_status.empty;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign out_valid         = out_valid_r;
  assign out_random_value  = out_random_r;
  assign out_unit_fraction = out_frac_r;
  assign out_seed_error    = out_err_r;

  // Order the bounds, then register the low end and the span in the cycle after the bound registers change
  assign lo_c = ($signed(upper_bound) < $signed(lower_bound)) ? upper_bound : lower_bound;
  assign hi_c = ($signed(upper_bound) < $signed(lower_bound)) ? lower_bound : upper_bound;

  always_ff @(posedge clk) begin
    lo_r   <= lo_c;
    span_r <= {hi_c[31], hi_c} - {lo_c[31], lo_c} + 33'd1;
  end

  // One shared multiplier takes the span in a low and a high half
  assign mul_b = (state_r == ST_MUL0) ? {1'b0, span_r[15:0]} : span_r[32:16];
  assign mul_p = 48'(seed_r) * 48'(mul_b);
  assign total = {p1_r, 16'd0} + {16'd0, p0_r};

  // Sequence one transaction
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = (head.draw && !head.err) ? ST_MUL0 : ST_DONE;
        end
      end
      ST_MUL0: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath; the offset is always below the span, so the sum stays within bounds
  always_ff @(posedge clk) begin
    if (q_pop) begin
      seed_r  <= head.seed;
      err_r   <= head.err;
      value_r <= 32'd0;
    end
    if (state_r == ST_MUL0) p0_r <= mul_p;
    if (state_r == ST_MUL1) p1_r <= mul_p;
    if (state_r == ST_SUM)  value_r <= lo_r + total[62:31];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_random_r <= value_r;
      out_frac_r   <= seed_r;
      out_err_r    <= err_r;
    end
  end

  a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("finished transaction not presented");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_random_r == 32'd0))
    else $error("seed error with non-zero value");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_MUL0 || state_r == ST_DONE))
    else $error("popped entry not sequenced");

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ulcg_pkg::*;

  typedef struct packed {
    logic signed [31:0] random_value;
    logic [30:0]        unit_fraction;
    logic               seed_error;
  } lcg_result_t;

  typedef struct packed {
    logic        op;
    logic [30:0] seed;
    logic        typed;
    lcg_result_t want;
  } stim_row_t;

  localparam int N_DIRECTED = 20;
  localparam int N_PHASES   = 9;
  localparam int PHASE_LEN  = 170;
  localparam int HOLD_LEN   = 60;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_operation;
  logic [30:0]          in_seed_value;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [31:0]   out_random_value;
  logic [30:0]          out_unit_fraction;
  logic                 out_seed_error;

  // Generator state as the testbench sees it
  logic [30:0]          gen_seed;
  logic signed [31:0]   bound_lo;
  logic signed [31:0]   bound_hi;

  lcg_result_t          draws_due[$];
  lcg_result_t          oldest_draw;
  int                   fails;
  bit                   quiet;
  int                   hold_req;

  stim_row_t            directed_rows [N_DIRECTED];
  logic signed [31:0]   phase_lo [N_PHASES];
  logic signed [31:0]   phase_hi [N_PHASES];

  uniform_integer_lcg_generator_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_seed_value     (in_seed_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_random_value  (out_random_value),
    .out_unit_fraction (out_unit_fraction),
    .out_seed_error    (out_seed_error)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Limit on the whole run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Seed recurrence: seed * 16807 mod (2^31-1)
  function automatic logic [30:0] lcg_advance(input logic [30:0] s);
    longint unsigned prod;
    prod = longint'(s) * longint'(LCG_MULT);
    return 31'(prod % longint'(LCG_MOD));
  endfunction

  // Work out the result of one transaction and update the tracked seed
  task automatic forecast_item(input logic op, input logic [30:0] sv,
                               output lcg_result_t r);
    longint lo;
    longint hi;
    longint swap;
    longint val;
    longint unsigned span;
    longint unsigned seed64;
    r = '0;
    if (op == OP_LOAD) begin
      if (sv == '0 || sv == LCG_MOD) r.seed_error = 1'b1;
      else gen_seed = sv;
      r.unit_fraction = gen_seed;
    end else if (gen_seed == '0) begin
      r.seed_error = 1'b1;
    end else begin
      lo = longint'(bound_lo);
      hi = longint'(bound_hi);
      if (hi < lo) begin
        swap = lo;
        lo = hi;
        hi = swap;
      end
      gen_seed = lcg_advance(gen_seed);
      r.unit_fraction = gen_seed;
      span = longint'(hi - lo) + 1;
      seed64 = longint'(gen_seed);
      val = lo + longint'((seed64 * span) >> 31);
      if (val < lo) val = lo;
      if (val > hi) val = hi;
      r.random_value = val[31:0];
    end
  endtask

  // Offer one transaction, after a random gap, and hold it until accepted
  task automatic send_item(input logic op, input logic [30:0] sv,
                           input logic typed, input lcg_result_t want);
    lcg_result_t pred;
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_seed_value <= sv;
    forecast_item(op, sv, pred);
    draws_due.push_back(typed ? want : pred);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until the block has drained
  task automatic drain;
    in_valid <= 1'b0;
    while (draws_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write both bound registers on consecutive cycles
  task automatic set_bounds(input logic signed [31:0] lo, input logic signed [31:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOWER;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= CFG_UPPER;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we    <= 1'b0;
    bound_lo = lo;
    bound_hi = hi;
  endtask

  // Receiver: random back-pressure, or a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        out_ready <= 1'b0;
        repeat (hold_req - 1) @(negedge clk);
        hold_req = 0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 11);
      end
    end
  end

  // Compare each result transaction with the oldest outstanding one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (draws_due.size() == 0) begin
        $error("result transaction with nothing outstanding");
        fails++;
      end else begin
        oldest_draw = draws_due.pop_front();
        if (out_random_value !== oldest_draw.random_value) begin
          $error("random_value: expected %0d, got %0d",
                 oldest_draw.random_value, out_random_value);
          fails++;
        end
        if (out_unit_fraction !== oldest_draw.unit_fraction) begin
          $error("unit_fraction: expected %0d, got %0d",
                 oldest_draw.unit_fraction, out_unit_fraction);
          fails++;
        end
        if (out_seed_error !== oldest_draw.seed_error) begin
          $error("seed_error: expected %0b, got %0b",
                 oldest_draw.seed_error, out_seed_error);
          fails++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic        op;
    logic [30:0] sv;
    int          pick;
    fails         = 0;
    quiet         = 1'b0;
    hold_req      = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_LOWER;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_operation  = OP_DRAW;
    in_seed_value = '0;

    // Directed rows; typed results hold from the reset seed of one and bounds 0..255
    directed_rows = '{
      '{OP_LOAD, 31'd0,          1'b1, '{32'sd0, 31'd1,          1'b1}},
      '{OP_LOAD, 31'h7FFF_FFFF,  1'b1, '{32'sd0, 31'd1,          1'b1}},
      '{OP_DRAW, 31'h7FFF_FFFF,  1'b1, '{32'sd0, 31'd16807,      1'b0}},
      '{OP_LOAD, 31'h7FFF_FFFE,  1'b1, '{32'sd0, 31'h7FFF_FFFE,  1'b0}},
      '{OP_DRAW, 31'd0,          1'b0, '0},
      '{OP_LOAD, 31'd1,          1'b1, '{32'sd0, 31'd1,          1'b0}},
      '{OP_DRAW, 31'h2AAA_AAAA,  1'b1, '{32'sd0, 31'd16807,      1'b0}},
      '{OP_DRAW, 31'h5555_5555,  1'b0, '0},
      '{OP_DRAW, 31'd0,          1'b0, '0},
      '{OP_LOAD, 31'h4000_0000,  1'b1, '{32'sd0, 31'h4000_0000,  1'b0}},
      '{OP_DRAW, 31'd0,          1'b0, '0},
      '{OP_LOAD, 31'h5555_5555,  1'b1, '{32'sd0, 31'h5555_5555,  1'b0}},
      '{OP_DRAW, 31'h7FFF_FFFF,  1'b0, '0},
      '{OP_LOAD, 31'd0,          1'b0, '0},
      '{OP_DRAW, 31'd0,          1'b0, '0},
      '{OP_LOAD, 31'h7FFF_FFFF,  1'b0, '0},
      '{OP_DRAW, 31'h2AAA_AAAA,  1'b0, '0},
      '{OP_LOAD, 31'h2AAA_AAAA,  1'b1, '{32'sd0, 31'h2AAA_AAAA,  1'b0}},
      '{OP_DRAW, 31'd0,          1'b0, '0},
      '{OP_DRAW, 31'h7FFF_FFFF,  1'b0, '0}
    };

    // Bound settings per phase: full range, reversed, single values, reversed +-1000, 0..1, random
    phase_lo = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd5, 32'sd1000, 32'sh8000_0000,
                 32'sh7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0};
    phase_hi = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd5, -32'sd1000, 32'sh8000_0000,
                 32'sh7FFF_FFFF, 32'sd1, 32'sd0, 32'sd0};
    phase_lo[7] = $urandom;
    phase_hi[7] = $urandom;
    phase_lo[8] = $urandom;
    phase_hi[8] = $urandom;

    // Reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    gen_seed = SEED_RST;
    bound_lo = LOWER_RST;
    bound_hi = UPPER_RST;
    @(negedge clk);

    // Walk the directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(directed_rows[i].op, directed_rows[i].seed,
                directed_rows[i].typed, directed_rows[i].want);
    end
    drain();

    // Random phases, each with its own bounds
    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_bounds(phase_lo[ph], phase_hi[ph]);
      quiet = (ph == 2);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (ph == 3 && n == 40) hold_req = HOLD_LEN;
        pick = $urandom_range(99);
        sv   = 31'($urandom);
        op   = (pick < 85) ? OP_DRAW : OP_LOAD;
        if (pick >= 95) begin
          case (pick % 4)
            0: sv = '0;
            1: sv = LCG_MOD;
            2: sv = LCG_MOD - 31'd1;
            default: sv = 31'd1;
          endcase
        end
        send_item(op, sv, 1'b0, '0);
      end
      quiet = 1'b0;
      drain();
    end

    repeat (12) @(negedge clk);
    if (fails == 0 && draws_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/ulcg_pkg.sv
design/ulcg_front.sv
design/ulcg_queue.sv
design/ulcg_back.sv
design/uniform_integer_lcg_generator_core.sv
tb/tb.sv
